// ----- hw/rtl/slmb_pkg.sv -----
// ----------------------------------------------------------------------------
// slmb_pkg
// Shared types, constants and arithmetic for the stereo level meter
// ballistics unit.
// ----------------------------------------------------------------------------
`default_nettype none

package slmb_pkg;

	localparam int LEVEL_FRAC_BITS = 16;
	localparam int LEVEL_W         = LEVEL_FRAC_BITS + 1;
	localparam int COEF_W          = 16;
	localparam int COUNT_W         = 16;
	localparam int PROD_W          = LEVEL_W + COEF_W;

	typedef logic [LEVEL_W-1:0] level_t;
	typedef logic [COEF_W-1:0]  coef_t;
	typedef logic [COUNT_W-1:0] count_t;
	typedef logic [PROD_W-1:0]  prod_t;

	localparam level_t FULL_SCALE = level_t'(1) << LEVEL_FRAC_BITS;
	localparam count_t COUNT_MAX  = '1;

	localparam coef_t  ATTACK_RST  = coef_t'(26214);
	localparam coef_t  RELEASE_RST = coef_t'(9830);
	localparam coef_t  FALLOFF_RST = coef_t'(13107);
	localparam count_t HOLD_RST    = count_t'(50);

	typedef enum logic [1:0] {
		REG_ATTACK  = 2'd0,
		REG_RELEASE = 2'd1,
		REG_FALLOFF = 2'd2,
		REG_HOLD    = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_SM,
		ST_APP_SM,
		ST_MUL_PK,
		ST_APP_PK,
		ST_FIN
	} state_t;

	// per-lane step strobes from the sequencer
	typedef struct packed {
		logic upd;
		logic mul_sm;
		logic app_sm;
		logic mul_pk;
		logic app_pk;
	} lane_ctl_t;

	function automatic level_t sat_level(input level_t v);
		sat_level = (v > FULL_SCALE) ? FULL_SCALE : v;
	endfunction

	// one glide step: floor toward target, given the registered product
	function automatic level_t glide_apply(input level_t cur, input prod_t prod,
		input logic rising);
		logic [PROD_W:0] rnd;
		level_t          dn;
		rnd = {1'b0, prod} + (PROD_W+1)'(2**COEF_W - 1);
		dn  = rnd[PROD_W-1 -: LEVEL_W];
		if (rising) begin
			glide_apply = cur + prod[PROD_W-1 -: LEVEL_W];
		end else begin
			glide_apply = cur - dn;
		end
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/slmb_lane.sv -----
// ----------------------------------------------------------------------------
// slmb_lane
// One channel of the meter: target, smoothed level, held peak and hold count,
// with a registered multiply before each glide step.
// ----------------------------------------------------------------------------
`default_nettype none

module slmb_lane
	import slmb_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire lane_ctl_t ctl,
	input  wire level_t    level_in,
	input  wire coef_t     attack_coeff,
	input  wire coef_t     release_coeff,
	input  wire coef_t     falloff_coeff,
	input  wire count_t    hold_ticks,
	output level_t         level,
	output level_t         peak
);

	level_t tgt_q;
	level_t smooth_q;
	level_t peak_q;
	count_t count_q;

	prod_t  prod_s1;
	logic   rise_s1;
	logic   expired_s2;
	prod_t  prod_s3;
	logic   rise_s3;

	level_t lvl_sat;
	logic   sm_rise;
	level_t sm_diff;
	logic   pk_rise;
	level_t pk_diff;
	count_t count_inc;
	coef_t  sm_coef;

	always_comb begin
		lvl_sat   = sat_level(level_in);
		sm_rise   = tgt_q > smooth_q;
		sm_diff   = sm_rise ? (tgt_q - smooth_q) : (smooth_q - tgt_q);
		sm_coef   = sm_rise ? attack_coeff : release_coeff;
		pk_rise   = smooth_q > peak_q;
		pk_diff   = pk_rise ? (smooth_q - peak_q) : (peak_q - smooth_q);
		count_inc = (count_q == COUNT_MAX) ? count_q : count_q + count_t'(1);
	end

	always_ff @(posedge clk) begin
		if (ctl.mul_sm) begin
			prod_s1 <= prod_t'(sm_diff) * prod_t'(sm_coef);
			rise_s1 <= sm_rise;
		end
		if (ctl.app_sm) begin
			expired_s2 <= count_inc > hold_ticks;
		end
		if (ctl.mul_pk) begin
			prod_s3 <= prod_t'(pk_diff) * prod_t'(falloff_coeff);
			rise_s3 <= pk_rise;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tgt_q    <= '0;
			smooth_q <= '0;
			peak_q   <= '0;
			count_q  <= '0;
		end else begin
			if (ctl.upd) begin
				tgt_q <= lvl_sat;
				if (lvl_sat > peak_q) begin
					peak_q  <= lvl_sat;
					count_q <= '0;
				end
			end
			if (ctl.app_sm) begin
				smooth_q <= glide_apply(smooth_q, prod_s1, rise_s1);
				count_q  <= count_inc;
			end
			if (ctl.app_pk && expired_s2) begin
				peak_q <= glide_apply(peak_q, prod_s3, rise_s3);
			end
		end
	end

	assign level = smooth_q;
	assign peak  = peak_q;

endmodule

`default_nettype wire

// ----- hw/rtl/stereo_level_meter_ballistics_unit.sv -----
// ----------------------------------------------------------------------------
// stereo_level_meter_ballistics_unit
// Two-lane meter ballistics: attack/release smoothing and peak hold/decay.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries req_type, left_in, right_in.
//   req_type 0 loads new targets and may capture new peaks; req_type 1 is a
//   display tick that glides levels and ages peaks.
//   Output channel (out_valid/out_stall) returns one item per input item with
//   both smoothed levels and both peaks after the update.
//   A level update goes through ST_FIN, a tick through ST_MUL_SM, ST_APP_SM,
//   ST_MUL_PK, ST_APP_PK and ST_FIN, before out_valid; the two lanes share
//   one sequencer, so one item is in work at a time (in_stall outside ST_IDLE)
//   and each tick passes two multiply-then-apply steps per lane.
//   A finished result waits in the output register; the next item is taken
//   meanwhile, and its result is held back while out_stall keeps the
//   previous one.
//   Reset clears all levels, peaks and hold counts and loads the default
//   coefficients. Configuration writes (cfg_we, cfg_index, cfg_wdata) are
//   taken at any edge and are meant for idle periods.
// ----------------------------------------------------------------------------
`default_nettype none

module stereo_level_meter_ballistics_unit
	import slmb_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   in_valid,
	output logic        in_stall,
	input  wire logic   req_type,
	input  wire level_t left_in,
	input  wire level_t right_in,
	output logic        out_valid,
	input  wire logic   out_stall,
	output level_t      left_level,
	output level_t      right_level,
	output level_t      left_peak,
	output level_t      right_peak,
	input  wire logic   cfg_we,
	input  wire logic [1:0] cfg_index,
	input  wire logic [COEF_W-1:0] cfg_wdata
);

	coef_t  attack_q;
	coef_t  release_q;
	coef_t  falloff_q;
	count_t hold_q;

	state_t    state_q;
	state_t    state_nx;
	lane_ctl_t ctl;
	logic      in_acc;
	logic      out_load;
	logic      out_valid_q;

	level_t l_level;
	level_t r_level;
	level_t l_peak;
	level_t r_peak;
	level_t l_level_q;
	level_t r_level_q;
	level_t l_peak_q;
	level_t r_peak_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attack_q  <= ATTACK_RST;
			release_q <= RELEASE_RST;
			falloff_q <= FALLOFF_RST;
			hold_q    <= HOLD_RST;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_ATTACK:  attack_q  <= cfg_wdata;
				REG_RELEASE: release_q <= cfg_wdata;
				REG_FALLOFF: falloff_q <= cfg_wdata;
				REG_HOLD:    hold_q    <= count_t'(cfg_wdata);
				default:     ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		ctl      = '0;
		out_load = 1'b0;
		in_stall = (state_q != ST_IDLE);
		in_acc   = in_valid && (state_q == ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (req_type) begin
						state_nx = ST_MUL_SM;
					end else begin
						ctl.upd  = 1'b1;
						state_nx = ST_FIN;
					end
				end
			end
			ST_MUL_SM: begin
				ctl.mul_sm = 1'b1;
				state_nx   = ST_APP_SM;
			end
			ST_APP_SM: begin
				ctl.app_sm = 1'b1;
				state_nx   = ST_MUL_PK;
			end
			ST_MUL_PK: begin
				ctl.mul_pk = 1'b1;
				state_nx   = ST_APP_PK;
			end
			ST_APP_PK: begin
				ctl.app_pk = 1'b1;
				state_nx   = ST_FIN;
			end
			ST_FIN: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	slmb_lane u_lane_l (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.level_in      (left_in),
		.attack_coeff  (attack_q),
		.release_coeff (release_q),
		.falloff_coeff (falloff_q),
		.hold_ticks    (hold_q),
		.level         (l_level),
		.peak          (l_peak)
	);

	slmb_lane u_lane_r (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.level_in      (right_in),
		.attack_coeff  (attack_q),
		.release_coeff (release_q),
		.falloff_coeff (falloff_q),
		.hold_ticks    (hold_q),
		.level         (r_level),
		.peak          (r_peak)
	);

	// merge both lanes into the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			l_level_q <= l_level;
			r_level_q <= r_level;
			l_peak_q  <= l_peak;
			r_peak_q  <= r_peak;
		end
	end

	assign out_valid   = out_valid_q;
	assign left_level  = l_level_q;
	assign right_level = r_level_q;
	assign left_peak   = l_peak_q;
	assign right_peak  = r_peak_q;

	a_tick_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && req_type |=> state_q == ST_MUL_SM)
		else $error("tick did not start the smoothing multiply");

	a_update_fin: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && !req_type |=> state_q == ST_FIN)
		else $error("level update did not go to finish");

	a_load_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_FIN)
		else $error("result loaded outside finish");

	a_levels_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (l_level_q <= FULL_SCALE) && (r_level_q <= FULL_SCALE))
		else $error("smoothed level above full scale");

	a_peaks_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (l_peak_q <= FULL_SCALE) && (r_peak_q <= FULL_SCALE))
		else $error("peak above full scale");

endmodule

`default_nettype wire

// ----- test/slmb_tb_pkg.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// slmb_tb_pkg
// Request kinds shared by the meter testbench top and its checker.
// ----------------------------------------------------------------------------
package slmb_tb_pkg;

	localparam logic REQ_LEVEL = 1'b0;
	localparam logic REQ_TICK  = 1'b1;

endpackage

// ----- test/slmb_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// slmb_checker
// Watches the register port and both item channels of the meter unit, keeps
// its own copy of the ballistics state, predicts the reading for every
// accepted item and compares it with the readings the unit hands out.
// ----------------------------------------------------------------------------
module slmb_checker
	import slmb_pkg::*;
	import slmb_tb_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_stall,
	input  logic              req_type,
	input  level_t            left_in,
	input  level_t            right_in,
	input  logic              out_valid,
	input  logic              out_stall,
	input  level_t            left_level,
	input  level_t            right_level,
	input  level_t            left_peak,
	input  level_t            right_peak,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [COEF_W-1:0] cfg_wdata,
	output int                outstanding,
	output int                mismatches
);

	typedef logic [PROD_W:0] wide_t;

	typedef struct packed {
		level_t left_level;
		level_t right_level;
		level_t left_peak;
		level_t right_peak;
	} meter_reading_t;

	meter_reading_t readings_due[$];

	coef_t  attack_k, release_k, falloff_k;
	count_t hold_limit;
	level_t target_l, target_r, smooth_l, smooth_r, peak_l, peak_r;
	count_t age_l, age_r;

	// floor toward the goal when rising, ceiling of the step when falling
	function automatic level_t glide_toward(input level_t cur, input level_t goal,
		input coef_t up, input coef_t down);
		wide_t prod;
		if (goal > cur) begin
			prod = wide_t'(goal - cur) * wide_t'(up);
			return cur + level_t'(prod >> COEF_W);
		end
		if (goal < cur) begin
			prod = wide_t'(cur - goal) * wide_t'(down) + wide_t'(16'hFFFF);
			return cur - level_t'(prod >> COEF_W);
		end
		return cur;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		meter_reading_t seen, due;
		level_t lvl_l, lvl_r;
		if (!arst_n) begin
			readings_due.delete();
			attack_k    = ATTACK_RST;
			release_k   = RELEASE_RST;
			falloff_k   = FALLOFF_RST;
			hold_limit  = HOLD_RST;
			target_l    = '0;
			target_r    = '0;
			smooth_l    = '0;
			smooth_r    = '0;
			peak_l      = '0;
			peak_r      = '0;
			age_l       = '0;
			age_r       = '0;
			mismatches  = 0;
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				case (reg_idx_t'(cfg_index))
					REG_ATTACK:  attack_k   = cfg_wdata;
					REG_RELEASE: release_k  = cfg_wdata;
					REG_FALLOFF: falloff_k  = cfg_wdata;
					REG_HOLD:    hold_limit = cfg_wdata;
				endcase
			end

			if (out_valid && !out_stall) begin
				seen = '{left_level, right_level, left_peak, right_peak};
				if (readings_due.size() == 0) begin
					if (mismatches < 10)
						$display("%0t: unexpected reading %0d %0d %0d %0d", $time,
							seen.left_level, seen.right_level, seen.left_peak, seen.right_peak);
					mismatches++;
				end else begin
					due = readings_due.pop_front();
					if (seen.left_level != due.left_level || seen.right_level != due.right_level ||
						seen.left_peak != due.left_peak || seen.right_peak != due.right_peak) begin
						if (mismatches < 10)
							$display("%0t: reading mismatch, expected %0d %0d %0d %0d, got %0d %0d %0d %0d",
								$time, due.left_level, due.right_level, due.left_peak, due.right_peak,
								seen.left_level, seen.right_level, seen.left_peak, seen.right_peak);
						mismatches++;
					end
				end
			end

			if (in_valid && !in_stall) begin
				if (req_type == REQ_LEVEL) begin
					lvl_l    = (left_in > FULL_SCALE) ? FULL_SCALE : left_in;
					lvl_r    = (right_in > FULL_SCALE) ? FULL_SCALE : right_in;
					target_l = lvl_l;
					target_r = lvl_r;
					if (lvl_l > peak_l) begin
						peak_l = lvl_l;
						age_l  = '0;
					end
					if (lvl_r > peak_r) begin
						peak_r = lvl_r;
						age_r  = '0;
					end
				end else begin
					smooth_l = glide_toward(smooth_l, target_l, attack_k, release_k);
					smooth_r = glide_toward(smooth_r, target_r, attack_k, release_k);
					if (age_l != COUNT_MAX)
						age_l = age_l + 1'b1;
					if (age_r != COUNT_MAX)
						age_r = age_r + 1'b1;
					if (age_l > hold_limit)
						peak_l = glide_toward(peak_l, smooth_l, falloff_k, falloff_k);
					if (age_r > hold_limit)
						peak_r = glide_toward(peak_r, smooth_r, falloff_k, falloff_k);
				end
				readings_due.push_back('{smooth_l, smooth_r, peak_l, peak_r});
			end

			outstanding <= readings_due.size();
		end
	end

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the stereo level meter ballistics unit: directed
// level and tick items at the reset and extreme coefficients, a run of ticks that
// carries the hold counts past the hold limit, then random bursts under
// several register settings with random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_top;
	import slmb_pkg::*;
	import slmb_tb_pkg::*;

	logic              clk       = 1'b0;
	logic              arst_n;
	logic              in_valid  = 1'b0;
	logic              in_stall;
	logic              req_type  = REQ_LEVEL;
	level_t            left_in   = '0;
	level_t            right_in  = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	level_t            left_level, right_level, left_peak, right_peak;
	logic              cfg_we    = 1'b0;
	logic [1:0]        cfg_index = '0;
	logic [COEF_W-1:0] cfg_wdata = '0;
	int                outstanding, mismatches;
	logic              stall_on  = 1'b1;
	int                stall_run = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	stereo_level_meter_ballistics_unit dut (.*);

	slmb_checker u_meter_check (.*);

	// receiver: alternating stall and free runs, sometimes long free stretches
	always @(posedge clk) begin
		if (!stall_on) begin
			out_stall <= 1'b0;
			stall_run <= 0;
		end else if (stall_run > 0) begin
			stall_run <= stall_run - 1;
		end else begin
			out_stall <= !out_stall;
			if (out_stall)
				stall_run <= ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
					: $urandom_range(0, 10);
			else
				stall_run <= $urandom_range(0, 12);
		end
	end

	task automatic push_item(input logic kind, input level_t l, input level_t r);
		in_valid <= 1'b1;
		req_type <= kind;
		left_in  <= l;
		right_in <= r;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	task automatic load_ballistics(input coef_t atk, input coef_t rel, input coef_t fall,
		input count_t hold);
		cfg_we    <= 1'b1;
		cfg_index <= REG_ATTACK;
		cfg_wdata <= atk;
		@(posedge clk);
		cfg_index <= REG_RELEASE;
		cfg_wdata <= rel;
		@(posedge clk);
		cfg_index <= REG_FALLOFF;
		cfg_wdata <= fall;
		@(posedge clk);
		cfg_index <= REG_HOLD;
		cfg_wdata <= hold;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic level_t any_level();
		case ($urandom_range(0, 3))
			0: any_level = level_t'($urandom);
			1: any_level = level_t'($urandom_range(65530, 65542));
			2: any_level = level_t'($urandom_range(0, 64));
			default: any_level = level_t'($urandom_range(0, 65536));
		endcase
	endfunction

	task automatic run_random(input int count);
		int burst, gap, tick_share;
		burst = 0;
		tick_share = 6;
		for (int i = 0; i < count; i++) begin
			if (burst == 0) begin
				burst      = $urandom_range(1, 16);
				tick_share = $urandom_range(2, 10);
				gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
				if (gap > 0) begin
					in_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			burst--;
			if ($urandom_range(0, 9) < tick_share)
				push_item(REQ_TICK, level_t'($urandom), level_t'($urandom));
			else
				push_item(REQ_LEVEL, any_level(), any_level());
		end
	endtask

	initial begin
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset coefficients: ignored tick inputs, saturation, attack and release
		push_item(REQ_TICK, '1, '1);
		push_item(REQ_LEVEL, '0, '0);
		push_item(REQ_LEVEL, '1, FULL_SCALE + 1'b1);
		push_item(REQ_LEVEL, FULL_SCALE, FULL_SCALE - 1'b1);
		repeat (3) push_item(REQ_TICK, '0, '0);
		push_item(REQ_LEVEL, '0, level_t'(1));
		repeat (3) push_item(REQ_TICK, level_t'(17'h0AAAA), level_t'(17'h15555));
		settle();

		// full-scale coefficients, no hold
		load_ballistics('1, '1, '1, '0);
		push_item(REQ_LEVEL, level_t'(17'h15555), level_t'(17'h0AAAA));
		repeat (2) push_item(REQ_TICK, '0, '0);
		push_item(REQ_LEVEL, '0, '0);
		repeat (2) push_item(REQ_TICK, '0, '0);
		settle();

		// zero coefficients: the ticks move neither levels nor peaks
		load_ballistics('0, '0, '0, count_t'(1));
		push_item(REQ_LEVEL, FULL_SCALE, level_t'(40000));
		repeat (3) push_item(REQ_TICK, '0, '0);
		settle();

		// hold expiry: peaks stay for the hold limit, then fall slowly
		load_ballistics('1, '1, '1, '0);
		push_item(REQ_LEVEL, '0, '0);
		repeat (2) push_item(REQ_TICK, '0, '0);
		settle();
		load_ballistics('1, '1, coef_t'(1), count_t'(20));
		stall_on <= 1'b0;
		push_item(REQ_LEVEL, FULL_SCALE, FULL_SCALE);
		push_item(REQ_LEVEL, '0, '0);
		repeat (60) push_item(REQ_TICK, level_t'($urandom), level_t'($urandom));
		settle();
		stall_on <= 1'b1;

		load_ballistics(coef_t'($urandom), coef_t'($urandom), coef_t'($urandom),
			count_t'($urandom_range(0, 8)));
		run_random(260);
		settle();
		load_ballistics('1, '1, '1, '0);
		run_random(260);
		settle();
		load_ballistics(coef_t'($urandom_range(1, 4096)), coef_t'($urandom_range(1, 4096)),
			coef_t'($urandom_range(1, 4096)), count_t'($urandom_range(0, 30)));
		run_random(260);
		settle();
		load_ballistics(ATTACK_RST, RELEASE_RST, FALLOFF_RST, HOLD_RST);
		run_random(260);
		settle();
		load_ballistics(coef_t'($urandom), coef_t'($urandom), coef_t'($urandom), '1);
		run_random(260);
		settle();

		repeat (10) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("stereo_level_meter_ballistics_unit test passed");
		else
			$display("stereo_level_meter_ballistics_unit test failed");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("stereo_level_meter_ballistics_unit test failed");
		$finish;
	end

endmodule

// ----- sim.f -----
hw/rtl/slmb_pkg.sv
hw/rtl/slmb_lane.sv
hw/rtl/stereo_level_meter_ballistics_unit.sv
test/slmb_tb_pkg.sv
test/slmb_checker.sv
test/tb_top.sv
